### rtl/qrm_pkg.sv
// Shared constants for the quaternion to rotation matrix unit.
// No dependencies.
package qrm_pkg;

  // matrix entries carried through the divider, row-major
  localparam int unsigned LANES = 9;

  typedef enum logic [3:0] {
    E_R0C0, E_R0C1, E_R0C2,
    E_R1C0, E_R1C1, E_R1C2,
    E_R2C0, E_R2C1, E_R2C2
  } entry_t;

endpackage

### rtl/quaternion_to_rotation_matrix_unit.sv
// A beat passes in turn through the product registers, the divider operand registers,
// the division steps and the output register. Throughput: one quaternion per cycle
// while the output is not stalled; the nine divisions run as one restoring step per
// pipeline stage, so the divider depth sets the latency, not the rate. A stalled output
// freezes the whole pipeline; in_stall follows it. Reset (rst_n, synchronous) clears
// the valid bits only; data registers are not reset. Depends on qrm_pkg.
module quaternion_to_rotation_matrix_unit
  import qrm_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_quat_w,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COMPONENT_WIDTH-1:0] out_r0c0,
  output logic signed [COMPONENT_WIDTH-1:0] out_r0c1,
  output logic signed [COMPONENT_WIDTH-1:0] out_r0c2,
  output logic signed [COMPONENT_WIDTH-1:0] out_r1c0,
  output logic signed [COMPONENT_WIDTH-1:0] out_r1c1,
  output logic signed [COMPONENT_WIDTH-1:0] out_r1c2,
  output logic signed [COMPONENT_WIDTH-1:0] out_r2c0,
  output logic signed [COMPONENT_WIDTH-1:0] out_r2c1,
  output logic signed [COMPONENT_WIDTH-1:0] out_r2c2,
  output logic                              out_zero_norm
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int PW = 2 * W;            // product width
  localparam int NW = 2 * W + 1;        // norm width
  localparam int SW = NW + 2;           // signed numerator width
  localparam int QW = FRACTION_BITS + 2;
  localparam int ST = FRACTION_BITS + 2; // division steps
  localparam logic [QW-2:0] ONE_MAG = (QW-1)'(1) << FRACTION_BITS;

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ---------------- products
  logic              v1_r;
  logic signed [PW-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic              zin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xx_r  <= in_quat_x * in_quat_x;
      yy_r  <= in_quat_y * in_quat_y;
      zz_r  <= in_quat_z * in_quat_z;
      ww_r  <= in_quat_w * in_quat_w;
      xy_r  <= in_quat_x * in_quat_y;
      xz_r  <= in_quat_x * in_quat_z;
      yz_r  <= in_quat_y * in_quat_z;
      wx_r  <= in_quat_w * in_quat_x;
      wy_r  <= in_quat_w * in_quat_y;
      wz_r  <= in_quat_w * in_quat_z;
      zin_r <= (in_quat_x == '0) && (in_quat_y == '0) &&
               (in_quat_z == '0) && (in_quat_w == '0);
    end
  end

  // ---------------- norm and numerators
  logic signed [SW-1:0] sxx, syy, szz, sn;
  logic signed [SW-1:0] num [LANES];
  logic [NW-1:0]        mag_nxt [LANES];
  logic [LANES-1:0]     neg_nxt;

  always_comb begin
    sxx = SW'(xx_r);
    syy = SW'(yy_r);
    szz = SW'(zz_r);
    sn  = sxx + syy + szz + SW'(ww_r);
    num[E_R0C0] = sn - ((syy + szz) <<< 1);
    num[E_R0C1] = (SW'(xy_r) + SW'(wz_r)) <<< 1;
    num[E_R0C2] = (SW'(xz_r) - SW'(wy_r)) <<< 1;
    num[E_R1C0] = (SW'(xy_r) - SW'(wz_r)) <<< 1;
    num[E_R1C1] = sn - ((sxx + szz) <<< 1);
    num[E_R1C2] = (SW'(yz_r) + SW'(wx_r)) <<< 1;
    num[E_R2C0] = (SW'(xz_r) + SW'(wy_r)) <<< 1;
    num[E_R2C1] = (SW'(yz_r) - SW'(wx_r)) <<< 1;
    num[E_R2C2] = sn - ((sxx + syy) <<< 1);
    for (int i = 0; i < LANES; i++) begin
      neg_nxt[i] = num[i][SW-1];
      mag_nxt[i] = neg_nxt[i] ? NW'(-num[i]) : NW'(num[i]);
    end
  end

  // ---------------- divider pipeline: index s holds the operands of step s
  logic              vd_r   [0:ST];
  logic              zero_r [0:ST];
  logic [NW-1:0]     n_r    [0:ST];
  logic [LANES-1:0]  neg_r  [0:ST];
  logic [NW-1:0]     rem_r  [0:ST][LANES];
  logic [QW-1:0]     q_r    [0:ST][LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (adv) begin
      vd_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r[0] <= zin_r;
      n_r[0]    <= NW'(sn);
      neg_r[0]  <= neg_nxt;
      for (int i = 0; i < LANES; i++) begin
        rem_r[0][i] <= mag_nxt[i];
        q_r[0][i]   <= '0;
      end
    end
  end

  for (genvar s = 0; s < ST; s++) begin : g_step
    logic [NW:0]   rr   [LANES];
    logic          ge   [LANES];
    logic [NW:0]   diff [LANES];

    always_comb begin
      for (int i = 0; i < LANES; i++) begin
        rr[i]   = (s == 0) ? {1'b0, rem_r[s][i]} : {rem_r[s][i], 1'b0};
        ge[i]   = rr[i] >= {1'b0, n_r[s]};
        diff[i] = rr[i] - {1'b0, n_r[s]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[s+1] <= 1'b0;
      end else if (adv) begin
        vd_r[s+1] <= vd_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        zero_r[s+1] <= zero_r[s];
        n_r[s+1]    <= n_r[s];
        neg_r[s+1]  <= neg_r[s];
        for (int i = 0; i < LANES; i++) begin
          rem_r[s+1][i] <= ge[i] ? diff[i][NW-1:0] : rr[i][NW-1:0];
          q_r[s+1][i]   <= {q_r[s][i][QW-2:0], ge[i]};
        end
      end
    end
  end

  // ---------------- round, clamp, sign, identity override
  logic [QW-1:0]        qinc [LANES];
  logic [QW-2:0]        qmag [LANES];
  logic signed [W-1:0]  ent_nxt [LANES];
  logic signed [W-1:0]  ent_r   [LANES];
  logic                 zn_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      qinc[i] = q_r[ST][i] + QW'(1);
      qmag[i] = qinc[i][QW-1:1];
      if (qmag[i] > ONE_MAG) begin
        qmag[i] = ONE_MAG;
      end
      ent_nxt[i] = neg_r[ST][i] ? -W'(qmag[i]) : W'(qmag[i]);
      if (zero_r[ST]) begin
        ent_nxt[i] = (i == E_R0C0 || i == E_R1C1 || i == E_R2C2) ? W'(ONE_MAG) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vd_r[ST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_r <= ent_nxt;
      zn_r  <= zero_r[ST];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_r0c0      = ent_r[E_R0C0];
  assign out_r0c1      = ent_r[E_R0C1];
  assign out_r0c2      = ent_r[E_R0C2];
  assign out_r1c0      = ent_r[E_R1C0];
  assign out_r1c1      = ent_r[E_R1C1];
  assign out_r1c2      = ent_r[E_R1C2];
  assign out_r2c0      = ent_r[E_R2C0];
  assign out_r2c1      = ent_r[E_R2C1];
  assign out_r2c2      = ent_r[E_R2C2];
  assign out_zero_norm = zn_r;

  // ---------------- checks
  a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid_r && out_stall))
    else $error("input stall does not track output backpressure");

  a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_norm) |->
      (out_r0c0 == W'(ONE_MAG) && out_r1c1 == W'(ONE_MAG) && out_r2c2 == W'(ONE_MAG) &&
       out_r0c1 == '0 && out_r1c2 == '0 && out_r2c0 == '0))
    else $error("zero quaternion did not give identity");

  a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vd_r[ST]) |=> out_valid)
    else $error("pipeline lost a result");

endmodule

### tb/sv/qrm_checker.sv
// Checker for the quaternion to rotation matrix unit: watches both channels,
// predicts each matrix from the accepted quaternion and compares field by field.
// Depends on qrm_pkg for the entry order.
module qrm_checker
  import qrm_pkg::*;
#(
  parameter int CW = 16,
  parameter int FB = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [CW-1:0] in_quat_x,
  input  logic signed [CW-1:0] in_quat_y,
  input  logic signed [CW-1:0] in_quat_z,
  input  logic signed [CW-1:0] in_quat_w,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [CW-1:0] out_r0c0,
  input  logic signed [CW-1:0] out_r0c1,
  input  logic signed [CW-1:0] out_r0c2,
  input  logic signed [CW-1:0] out_r1c0,
  input  logic signed [CW-1:0] out_r1c1,
  input  logic signed [CW-1:0] out_r1c2,
  input  logic signed [CW-1:0] out_r2c0,
  input  logic signed [CW-1:0] out_r2c1,
  input  logic signed [CW-1:0] out_r2c2,
  input  logic                 out_zero_norm,
  output int                   fail_count,
  output int                   pending,
  output int                   matrices_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CW-1:0] ent [LANES];
    logic          zero_norm;
  } matrix_t;

  matrix_t expected_matrices[$];
  int      mismatches;

  // ties away from zero, clamped to one
  function automatic logic [CW-1:0] scaled_ratio(longint num, longint n);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< (FB + 1)) / n + 1) >>> 1;
    if (q > (64'sd1 <<< FB)) q = 64'sd1 <<< FB;
    if (num < 0) q = -q;
    return q[CW-1:0];
  endfunction

  function automatic matrix_t rotation_of(longint x, longint y, longint z, longint w);
    matrix_t m;
    longint n;
    n = x*x + y*y + z*z + w*w;
    if (n == 0) begin
      foreach (m.ent[i]) m.ent[i] = '0;
      m.ent[E_R0C0] = 1 << FB;
      m.ent[E_R1C1] = 1 << FB;
      m.ent[E_R2C2] = 1 << FB;
      m.zero_norm = 1'b1;
      return m;
    end
    m.ent[E_R0C0] = scaled_ratio(n - 2*(y*y + z*z), n);
    m.ent[E_R0C1] = scaled_ratio(2*(x*y + w*z), n);
    m.ent[E_R0C2] = scaled_ratio(2*(x*z - w*y), n);
    m.ent[E_R1C0] = scaled_ratio(2*(x*y - w*z), n);
    m.ent[E_R1C1] = scaled_ratio(n - 2*(x*x + z*z), n);
    m.ent[E_R1C2] = scaled_ratio(2*(y*z + w*x), n);
    m.ent[E_R2C0] = scaled_ratio(2*(x*z + w*y), n);
    m.ent[E_R2C1] = scaled_ratio(2*(y*z - w*x), n);
    m.ent[E_R2C2] = scaled_ratio(n - 2*(x*x + y*y), n);
    m.zero_norm = 1'b0;
    return m;
  endfunction

  assign pending = expected_matrices.size();

  initial begin
    fail_count = 0;
    mismatches = 0;
    matrices_seen = 0;
  end

  always @(posedge clk) begin
    matrix_t want, got;
    if (rst_n && in_valid && !in_stall)
      expected_matrices.push_back(rotation_of(in_quat_x, in_quat_y, in_quat_z, in_quat_w));
    if (rst_n && out_valid && !out_stall) begin
      got.ent = '{out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
                  out_r2c0, out_r2c1, out_r2c2};
      got.zero_norm = out_zero_norm;
      matrices_seen++;
      if (expected_matrices.size() == 0) begin
        fail_count++;
        if (mismatches++ < 10) $display("ERROR: unexpected matrix beat at %0t", $realtime);
      end else begin
        want = expected_matrices.pop_front();
        if (want.ent != got.ent || want.zero_norm != got.zero_norm) begin
          fail_count++;
          if (mismatches++ < 10)
            $display("ERROR: beat %0d expected %p zn=%b, got %p zn=%b",
                     matrices_seen, want.ent, want.zero_norm, got.ent, got.zero_norm);
        end
      end
    end
  end
endmodule

### tb/sv/tb_quaternion_to_rotation_matrix_unit.sv
// Top of the quaternion to rotation matrix testbench: clock, reset, stimulus
// and verdict. Depends on qrm_pkg, qrm_checker and the unit itself.
module tb_quaternion_to_rotation_matrix_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int FB = 14;
  localparam int WATCHDOG = 20000;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, out_zero_norm;
  logic signed [CW-1:0] in_quat_x, in_quat_y, in_quat_z, in_quat_w;
  logic signed [CW-1:0] out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2;
  logic signed [CW-1:0] out_r2c0, out_r2c1, out_r2c2;
  int fail_count, pending, matrices_seen;
  int send_idle_pct, recv_idle_pct, quiet_cycles;

  quaternion_to_rotation_matrix_unit #(.COMPONENT_WIDTH(CW), .FRACTION_BITS(FB)) dut (.*);
  qrm_checker #(.CW(CW), .FB(FB)) checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver stall, re-rolled every cycle
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("tb_quaternion_to_rotation_matrix_unit failed");
      $finish;
    end
  end

  task automatic send_quat(logic [CW-1:0] x, y, z, w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_quat_x <= x;
    in_quat_y <= y;
    in_quat_z <= z;
    in_quat_w <= w;
    // hold the beat until accepted
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [CW-1:0] pick_component();
    case ($urandom_range(5))
      0:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      1:       return CW'($signed($urandom_range(8)) - 4);
      2:       return $urandom_range(1) ? 16'h4000 : 16'hc000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [CW-1:0] corner [8] = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff,
                                  16'h8000, 16'h4000, 16'hc000, 16'h2d41};
    rst_n = 0; in_valid = 0; out_stall = 0; quiet_cycles = 0;
    in_quat_x = '0; in_quat_y = '0; in_quat_z = '0; in_quat_w = '0;
    send_idle_pct = 21; recv_idle_pct = 74;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // zero quaternion, axis units, extremes, ties near small norms
    send_quat(0, 0, 0, 0);
    send_quat(16'h4000, 0, 0, 0);
    send_quat(0, 16'h4000, 0, 0);
    send_quat(0, 0, 16'h4000, 0);
    send_quat(0, 0, 0, 16'h4000);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(1, 0, 0, 0);
    send_quat(1, 1, 1, 1);
    send_quat(16'hffff, 1, 16'hffff, 1);
    send_quat(1, 2, 0, 3);
    send_quat(16'h2d41, 0, 0, 16'h2d41);
    send_quat(0, 16'h2d41, 16'hd2bf, 0);
    for (int i = 0; i < 8; i++)
      send_quat(corner[i], corner[(i+3)%8], corner[(i+5)%8], corner[(i+1)%8]);
    for (int i = 0; i < 1000; i++) begin
      if (i == 333) begin send_idle_pct = 74; recv_idle_pct = 21; end
      if (i == 666) begin send_idle_pct = 0; recv_idle_pct = 0; end
      send_quat(pick_component(), pick_component(), pick_component(), pick_component());
    end
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (FB + 10) @(posedge clk);
    $display("Run covered %0d quaternions (zero, extreme and random components)", 1022);
    $display("under three idle patterns; %0d matrices checked", matrices_seen);
    if (fail_count == 0 && pending == 0)
      $display("tb_quaternion_to_rotation_matrix_unit passed");
    else
      $display("tb_quaternion_to_rotation_matrix_unit failed");
    $finish;
  end
endmodule

### filelist.f
rtl/qrm_pkg.sv
rtl/quaternion_to_rotation_matrix_unit.sv
tb/sv/qrm_checker.sv
tb/sv/tb_quaternion_to_rotation_matrix_unit.sv
